FILE: rtl/lci_pkg.sv
// shared types, constants and colour table for the layer colour indicator
package lci_pkg;

  // layer setup
  localparam int LAYER_COUNT    = 10;
  localparam int SELECTOR_INDEX = 9;
  localparam int MASK_W         = 10;
  localparam int LAYER_W        = 5;

  // conversion constants
  localparam int HUE_WRAP     = 360;
  localparam int HUE_SECTOR   = 60;
  localparam int FULL_SCALE   = 255;
  localparam int RECIP100     = 5243;   // ceil(2^19 / 100)
  localparam int RECIP100_SH  = 19;

  typedef struct packed {
    logic [MASK_W-1:0] layer_mask;
    logic              underglow_on;
  } lci_in_t;

  typedef struct packed {
    logic [LAYER_W-1:0] layer_index;
    logic [8:0]         hue;
    logic [6:0]         saturation;
    logic [6:0]         brightness;
    logic               draw;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } lci_out_t;

  typedef struct packed {
    logic [8:0] hue;
    logic [6:0] sat;
    logic [6:0] brt;
  } lci_hsb_t;

  // per-layer colour; selector layer and layers past the fixed set read as zero
  function automatic lci_hsb_t colour_lookup(input logic [LAYER_W-1:0] layer);
    lci_hsb_t c;
    c = '0;
    case (layer)
      5'd0:    c = '{hue: 9'd0,   sat: 7'd0,   brt: 7'd80};
      5'd1:    c = '{hue: 9'd40,  sat: 7'd100, brt: 7'd80};
      5'd2:    c = '{hue: 9'd120, sat: 7'd100, brt: 7'd80};
      5'd3:    c = '{hue: 9'd180, sat: 7'd100, brt: 7'd80};
      5'd4:    c = '{hue: 9'd320, sat: 7'd100, brt: 7'd80};
      5'd5:    c = '{hue: 9'd25,  sat: 7'd100, brt: 7'd80};
      5'd6:    c = '{hue: 9'd225, sat: 7'd100, brt: 7'd80};
      5'd7:    c = '{hue: 9'd165, sat: 7'd100, brt: 7'd70};
      5'd8:    c = '{hue: 9'd280, sat: 7'd100, brt: 7'd80};
      default: c = '0;
    endcase
    if (layer == LAYER_W'(SELECTOR_INDEX)) begin
      c = '0;
    end
    return c;
  endfunction

  // floor(x / 255), exact while the quotient fits 8 bits (x up to 255*255)
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

FILE: rtl/layer_colour_indicator_top.sv
// layer colour indicator: layer pick, colour lookup and pipelined hsb to rgb
//
//   channel | direction | ports                         | payload
//   in      | input     | in_valid, in_ready, in_data   | lci_in_t
//   out     | output    | out_valid, out_ready, out_data | lci_out_t
//
// one request per cycle sustained while the output does not stall
// six register stages: pick, lookup/scale, products, divide, products, divide/mux
// the whole pipe advances together; it holds only while out_valid waits for out_ready
// synchronous active-low reset clears the stage valid bits, no clearing pass
module layer_colour_indicator_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lci_pkg::lci_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lci_pkg::lci_out_t out_data
);
  import lci_pkg::*;

  typedef struct packed {
    logic [LAYER_W-1:0] layer;
    logic               draw;
    logic               sel;
    logic [8:0]         hue;
    logic [6:0]         sat;
    logic [6:0]         brt;
  } side_t;

  // pipe advance and stage valid bits
  logic       adv;
  logic [5:0] vld_r;

  assign adv      = !vld_r[5] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  // stage 1: landing layer pick
  logic [LAYER_W-1:0] pick_nxt;
  logic [LAYER_W-1:0] s1_layer_r;
  logic               s1_draw_r, s1_sel_r;

  always_comb begin
    pick_nxt = '0;
    for (int i = 0; i < LAYER_COUNT; i++) begin
      if (i != SELECTOR_INDEX && i < MASK_W) begin
        if (in_data.layer_mask[i]) begin
          pick_nxt = LAYER_W'(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_layer_r <= pick_nxt;
      s1_draw_r  <= !in_data.underglow_on;
      s1_sel_r   <= (SELECTOR_INDEX < MASK_W) ? in_data.layer_mask[SELECTOR_INDEX] : 1'b0;
    end
  end

  // stage 2: table lookup, percent to 8-bit scale, hue sector split
  lci_hsb_t    hsb;
  logic [15:0] v255, s255;
  logic [28:0] vprod, sprod;
  logic [9:0]  vq, sq;
  logic [8:0]  hh, sect_base;
  logic [2:0]  region_nxt;
  side_t       s2_side_r;
  logic [7:0]  s2_vv_r, s2_ss_r;
  logic [2:0]  s2_region_r;
  logic [5:0]  s2_remraw_r;

  always_comb begin
    hsb   = colour_lookup(s1_layer_r);
    v255  = 16'(hsb.brt) * 16'(FULL_SCALE);
    s255  = 16'(hsb.sat) * 16'(FULL_SCALE);
    vprod = 29'(v255) * 29'(RECIP100);
    sprod = 29'(s255) * 29'(RECIP100);
    vq    = vprod[RECIP100_SH +: 10];
    sq    = sprod[RECIP100_SH +: 10];
    hh    = (hsb.hue >= 9'(HUE_WRAP)) ? hsb.hue - 9'(HUE_WRAP) : hsb.hue;
    if      (hh < 9'(HUE_SECTOR))     region_nxt = 3'd0;
    else if (hh < 9'(2 * HUE_SECTOR)) region_nxt = 3'd1;
    else if (hh < 9'(3 * HUE_SECTOR)) region_nxt = 3'd2;
    else if (hh < 9'(4 * HUE_SECTOR)) region_nxt = 3'd3;
    else if (hh < 9'(5 * HUE_SECTOR)) region_nxt = 3'd4;
    else                              region_nxt = 3'd5;
    sect_base = 9'(region_nxt) * 9'(HUE_SECTOR);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_side_r   <= '{layer: s1_layer_r, draw: s1_draw_r, sel: s1_sel_r,
                       hue: hsb.hue, sat: hsb.sat, brt: hsb.brt};
      s2_vv_r     <= (vq > 10'(FULL_SCALE)) ? 8'(FULL_SCALE) : vq[7:0];
      s2_ss_r     <= (sq > 10'(FULL_SCALE)) ? 8'(FULL_SCALE) : sq[7:0];
      s2_region_r <= region_nxt;
      s2_remraw_r <= 6'(hh - sect_base);
    end
  end

  // stage 3: sector remainder to 8-bit scale (x*255/60 = x*17/4) and first products
  logic [9:0]  rem17;
  logic [7:0]  rem;
  side_t       s3_side_r;
  logic [7:0]  s3_vv_r;
  logic        s3_grey_r;
  logic [2:0]  s3_region_r;
  logic [15:0] s3_pnum_r, s3_sr_r, s3_srn_r;

  assign rem17 = {s2_remraw_r, 4'd0} + 10'(s2_remraw_r);
  assign rem   = rem17[9:2];

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_side_r   <= s2_side_r;
      s3_vv_r     <= s2_vv_r;
      s3_grey_r   <= (s2_ss_r == 8'd0);
      s3_region_r <= s2_region_r;
      s3_pnum_r   <= 16'(s2_vv_r) * 16'(8'(FULL_SCALE) - s2_ss_r);
      s3_sr_r     <= 16'(s2_ss_r) * 16'(rem);
      s3_srn_r    <= 16'(s2_ss_r) * 16'(8'(FULL_SCALE) - rem);
    end
  end

  // stage 4: divide the first products by 255
  side_t      s4_side_r;
  logic [7:0] s4_vv_r, s4_p_r, s4_a_r, s4_b_r;
  logic       s4_grey_r;
  logic [2:0] s4_region_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_side_r   <= s3_side_r;
      s4_vv_r     <= s3_vv_r;
      s4_grey_r   <= s3_grey_r;
      s4_region_r <= s3_region_r;
      s4_p_r      <= div255(s3_pnum_r);
      s4_a_r      <= div255(s3_sr_r);
      s4_b_r      <= div255(s3_srn_r);
    end
  end

  // stage 5: falling and rising ramp products
  side_t       s5_side_r;
  logic [7:0]  s5_vv_r, s5_p_r;
  logic        s5_grey_r;
  logic [2:0]  s5_region_r;
  logic [15:0] s5_qnum_r, s5_tnum_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_side_r   <= s4_side_r;
      s5_vv_r     <= s4_vv_r;
      s5_p_r      <= s4_p_r;
      s5_grey_r   <= s4_grey_r;
      s5_region_r <= s4_region_r;
      s5_qnum_r   <= 16'(s4_vv_r) * 16'(8'(FULL_SCALE) - s4_a_r);
      s5_tnum_r   <= 16'(s4_vv_r) * 16'(8'(FULL_SCALE) - s4_b_r);
    end
  end

  // stage 6: final divide, sector mux, grey and selector masking
  logic [7:0] q, t, r_nxt, g_nxt, b_nxt;
  lci_out_t   out_r;

  always_comb begin
    q = div255(s5_qnum_r);
    t = div255(s5_tnum_r);
    case (s5_region_r)
      3'd0:    begin r_nxt = s5_vv_r; g_nxt = t;       b_nxt = s5_p_r;  end
      3'd1:    begin r_nxt = q;       g_nxt = s5_vv_r; b_nxt = s5_p_r;  end
      3'd2:    begin r_nxt = s5_p_r;  g_nxt = s5_vv_r; b_nxt = t;       end
      3'd3:    begin r_nxt = s5_p_r;  g_nxt = q;       b_nxt = s5_vv_r; end
      3'd4:    begin r_nxt = t;       g_nxt = s5_p_r;  b_nxt = s5_vv_r; end
      default: begin r_nxt = s5_vv_r; g_nxt = s5_p_r;  b_nxt = q;       end
    endcase
    if (s5_grey_r) begin
      r_nxt = s5_vv_r;
      g_nxt = s5_vv_r;
      b_nxt = s5_vv_r;
    end
    if (!s5_side_r.sel) begin
      r_nxt = '0;
      g_nxt = '0;
      b_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= '{layer_index: s5_side_r.layer, hue: s5_side_r.hue,
                 saturation: s5_side_r.sat, brightness: s5_side_r.brt,
                 draw: s5_side_r.draw, red: r_nxt, green: g_nxt, blue: b_nxt};
    end
  end

  assign out_valid = vld_r[5];
  assign out_data  = out_r;

  // checks
  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the output stall");

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_grey_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturation == 7'd0) |->
      (out_data.red == out_data.green && out_data.green == out_data.blue))
    else $error("grey colour with unequal channels");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.hue < 9'(HUE_WRAP)))
    else $error("hue out of range");

endmodule
